// File: rtl/csvft_pkg.sv
package csvft_pkg;

  localparam int unsigned MaxColumnsW = 10;
  localparam int unsigned MaxRowsW    = 16;
  localparam int unsigned CellsW      = 11;
  localparam int unsigned RowsW       = 17;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [MaxColumnsW-1:0] MaxColumnsReset = 10'd50;
  localparam logic [MaxRowsW-1:0]    MaxRowsReset    = 16'd100;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic {
    CFG_MAX_COLUMNS = 1'b0,
    CFG_MAX_ROWS    = 1'b1
  } cfg_index_t;

  typedef enum logic {
    FUNC_DATA = 1'b0,
    FUNC_END  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_ROW_END  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_COLUMNS    = 2'd0,
    ERR_ROWS       = 2'd1,
    ERR_QUOTE      = 2'd2,
    ERR_END_LIMITS = 2'd3
  } err_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] byte_in;
  } tok_in_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] cell_byte;
    err_t       error_code;
    logic       last_of_run;
  } tok_out_t;

  // Results of one item toward the output queue: zero, one or two words.
  typedef struct packed {
    logic [1:0] cnt;
    tok_out_t   r0;
    tok_out_t   r1;
  } tok_push_t;

endpackage

// File: rtl/csv_field_tokenizer.sv
// CSV field tokenizer.
// Input channel (in_valid / in_stall / in_word): one word per CSV byte with
// func = data, then one word with func = end to close the block. A word is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_word): cell bytes, cell ends,
// row ends and error codes, in text order. last_of_run marks the final
// word caused by one input word; an input word may cause none, one or two.
// A result appears on out_word in the cycle after its input word is taken
// when the queue ahead of it is empty. Input words are taken one per cycle
// while in_stall is low, set by the update of the quote flags and counters;
// a word that gives two results passes them out in order through a four-word
// output queue.
// in_stall rises when the queue holds more than two words, so a stalled
// receiver backs pressure up to the sender after at most three words.
// Limits max_columns / max_rows are written through cfg_we / cfg_index /
// cfg_data while the block is idle.
// Reset (rst, synchronous) empties the queue, clears the block state and
// loads the limits with 50 columns and 100 rows.
module csv_field_tokenizer
  import csvft_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tok_in_t             in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tok_out_t            out_word,
  input  logic                cfg_we,
  input  cfg_index_t          cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [MaxColumnsW-1:0] max_columns;
  logic [MaxRowsW-1:0]    max_rows;
  logic                   room;
  logic                   in_accept;
  tok_push_t              push;

  // Hold off the sender while the queue could not take a two-word burst.
  assign in_stall  = !room;
  assign in_accept = in_valid && room;

  // Limit registers; the upper data bits are dropped for the column limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_columns <= MaxColumnsReset;
      max_rows    <= MaxRowsReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_COLUMNS: max_columns <= cfg_data[MaxColumnsW-1:0];
        CFG_MAX_ROWS:    max_rows    <= cfg_data[MaxRowsW-1:0];
        default:         ;
      endcase
    end
  end

  // Quote tracking, counters and result generation, one word per cycle while in_stall is low.
  csvft_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .item        (in_word),
    .max_columns (max_columns),
    .max_rows    (max_rows),
    .push        (push)
  );

  // Result queue: separates the sender from a stalled receiver.
  csvft_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// File: rtl/csvft_core.sv
module csvft_core
  import csvft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  tok_in_t                item,
  input  logic [MaxColumnsW-1:0] max_columns,
  input  logic [MaxRowsW-1:0]    max_rows,
  output tok_push_t              push
);

  logic              in_quotes, in_quotes_next;
  logic              quote_pending, quote_pending_next;
  logic [CellsW-1:0] cells_in_row, cells_in_row_next;
  logic [RowsW-1:0]  rows_done, rows_done_next;
  logic              cell_has_bytes, cell_has_bytes_next;
  logic              failed, failed_next;

  logic [CellsW-1:0] cells_inc;
  logic [RowsW-1:0]  rows_inc;
  logic              col_over;
  logic              row_over;

  assign cells_inc = cells_in_row + CellsW'(1);
  assign rows_inc  = rows_done + RowsW'(1);
  assign col_over  = cells_inc > CellsW'(max_columns);
  assign row_over  = rows_inc > RowsW'(max_rows);

  always_comb begin
    logic q_eff;
    logic consumed;
    logic is_row;
    in_quotes_next      = in_quotes;
    quote_pending_next  = quote_pending;
    cells_in_row_next   = cells_in_row;
    rows_done_next      = rows_done;
    cell_has_bytes_next = cell_has_bytes;
    failed_next         = failed;
    push                = '0;
    q_eff               = in_quotes;
    consumed            = 1'b0;
    is_row              = 1'b0;

    if (item.func == FUNC_END) begin
      if (!failed) begin
        if (in_quotes && !quote_pending) begin
          push.cnt           = 2'd1;
          push.r0.kind       = KIND_ERROR;
          push.r0.error_code = ERR_QUOTE;
        end else if (cell_has_bytes || cells_in_row != '0) begin
          push.cnt     = 2'd1;
          push.r0.kind = KIND_ROW_END;
          if (col_over || row_over) begin
            push.cnt           = 2'd2;
            push.r1.kind       = KIND_ERROR;
            push.r1.error_code = ERR_END_LIMITS;
          end
        end
      end
      // End of block: clear everything but the limits.
      in_quotes_next      = 1'b0;
      quote_pending_next  = 1'b0;
      cells_in_row_next   = '0;
      rows_done_next      = '0;
      cell_has_bytes_next = 1'b0;
      failed_next         = 1'b0;
    end else if (!failed) begin
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (item.byte_in == ChQuote) begin
          // Doubled quote: one literal quote byte.
          consumed            = 1'b1;
          cell_has_bytes_next = 1'b1;
          push.cnt            = 2'd1;
          push.r0.kind        = KIND_BYTE;
          push.r0.cell_byte   = ChQuote;
        end else begin
          q_eff = 1'b0;
        end
      end
      in_quotes_next = q_eff;
      if (!consumed) begin
        if (item.byte_in == ChQuote) begin
          if (q_eff) begin
            quote_pending_next = 1'b1;
          end else begin
            in_quotes_next = 1'b1;
          end
        end else if (!q_eff && (item.byte_in == ChComma || item.byte_in == ChLf)) begin
          is_row       = (item.byte_in == ChLf);
          push.cnt     = 2'd1;
          push.r0.kind = is_row ? KIND_ROW_END : KIND_CELL_END;
          if (col_over) begin
            push.cnt           = 2'd2;
            push.r1.kind       = KIND_ERROR;
            push.r1.error_code = ERR_COLUMNS;
            failed_next        = 1'b1;
          end else begin
            cells_in_row_next   = cells_inc;
            cell_has_bytes_next = 1'b0;
            if (is_row) begin
              cells_in_row_next = '0;
              if (row_over) begin
                push.cnt           = 2'd2;
                push.r1.kind       = KIND_ERROR;
                push.r1.error_code = ERR_ROWS;
                failed_next        = 1'b1;
              end else begin
                rows_done_next = rows_inc;
              end
            end
          end
        end else if (item.byte_in != ChCr) begin
          cell_has_bytes_next = 1'b1;
          push.cnt            = 2'd1;
          push.r0.kind        = KIND_BYTE;
          push.r0.cell_byte   = item.byte_in;
        end
      end
    end

    if (push.cnt == 2'd2) begin
      push.r1.last_of_run = 1'b1;
    end else if (push.cnt == 2'd1) begin
      push.r0.last_of_run = 1'b1;
    end
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      quote_pending  <= 1'b0;
      cells_in_row   <= '0;
      rows_done      <= '0;
      cell_has_bytes <= 1'b0;
      failed         <= 1'b0;
    end else if (accept) begin
      in_quotes      <= in_quotes_next;
      quote_pending  <= quote_pending_next;
      cells_in_row   <= cells_in_row_next;
      rows_done      <= rows_done_next;
      cell_has_bytes <= cell_has_bytes_next;
      failed         <= failed_next;
    end
  end

`ifndef SYNTH
  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_DATA && failed) |-> push.cnt == 2'd0)
    else $error("data word produced results after an error");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_END) |=>
      (!failed && !in_quotes && !quote_pending && cells_in_row == '0 && rows_done == '0))
    else $error("end mark did not clear block state");
`endif

endmodule

// File: rtl/csvft_outq.sv
module csvft_outq
  import csvft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tok_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output tok_out_t  out_word
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tok_out_t          slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              pop;

  assign out_valid = (count != '0);
  assign out_word  = slots[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Room for the largest burst of one item.
  assign room      = (count <= CntW'(Depth - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      slots[wr_ptr + PtrW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.cnt);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CntW'(push.cnt) - CntW'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("output queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("output queue count out of range");
`endif

endmodule

// File: dv/csv_field_tokenizer_test.sv
`timescale 1ns / 1ps

module csv_field_tokenizer_test;
  import csvft_pkg::*;

  // Cycles without any accepted word before the run is called hung. This
  // leaves a wide margin over the pauses between phases.
  localparam int unsigned QuietLimit = 2000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tok_in_t             in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tok_out_t            out_word;
  logic                cfg_we    = 1'b0;
  cfg_index_t          cfg_index = CFG_MAX_COLUMNS;
  logic [CfgDataW-1:0] cfg_data  = '0;

  csv_field_tokenizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Tokenizer state as the checker sees it, plus its copy of the limits.
  // ---------------------------------------------------------------------
  logic [MaxColumnsW-1:0] lim_columns  = MaxColumnsReset;
  logic [MaxRowsW-1:0]    lim_rows     = MaxRowsReset;
  logic                   quoted       = 1'b0;
  logic                   quote_held   = 1'b0;  // quote inside quotes, not yet resolved
  logic                   cell_open    = 1'b0;  // current cell already has bytes
  logic                   block_failed = 1'b0;
  logic [CellsW-1:0]      row_cells    = '0;
  logic [RowsW-1:0]       block_rows   = '0;

  tok_in_t     pending_words[$];    // words waiting to be driven
  tok_out_t    expected_tokens[$];  // tokens the block still owes us
  tok_out_t    step_tokens[$];      // tokens of the word being tokenized
  int unsigned fail_count = 0;
  bit          steady = 1'b0;       // when set, neither side idles

  function automatic void emit(kind_t k, logic [7:0] b, err_t e);
    tok_out_t t;
    t.kind        = k;
    t.cell_byte   = b;
    t.error_code  = e;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endfunction

  // Close the current cell; on a newline also close the row. The column
  // limit is checked first, and an overflow kills the rest of the block.
  function automatic void close_cell(bit row_end);
    int unsigned cells;
    cells = row_cells + 1;
    if (row_end) begin
      emit(KIND_ROW_END, 8'h00, ERR_COLUMNS);
    end else begin
      emit(KIND_CELL_END, 8'h00, ERR_COLUMNS);
    end
    if (cells > lim_columns) begin
      emit(KIND_ERROR, 8'h00, ERR_COLUMNS);
      block_failed = 1'b1;
    end else begin
      row_cells = CellsW'(cells);
      cell_open = 1'b0;
      if (row_end) begin
        row_cells = '0;
        if (block_rows + 1 > lim_rows) begin
          emit(KIND_ERROR, 8'h00, ERR_ROWS);
          block_failed = 1'b1;
        end else begin
          block_rows = block_rows + 1'b1;
        end
      end
    end
  endfunction

  function automatic void take_byte(logic [7:0] c);
    bit done;
    done = 1'b0;
    // A held quote resolves now: a second quote is a literal quote, any
    // other byte closes the quotes and is then treated as unquoted.
    if (quote_held) begin
      quote_held = 1'b0;
      if (c == ChQuote) begin
        cell_open = 1'b1;
        emit(KIND_BYTE, c, ERR_COLUMNS);
        done = 1'b1;
      end else begin
        quoted = 1'b0;
      end
    end
    if (!done) begin
      if (c == ChQuote) begin
        if (quoted) begin
          quote_held = 1'b1;
        end else begin
          quoted = 1'b1;
        end
      end else if (!quoted && (c == ChComma || c == ChLf)) begin
        close_cell(c == ChLf);
      end else if (c != ChCr) begin
        cell_open = 1'b1;
        emit(KIND_BYTE, c, ERR_COLUMNS);
      end
    end
  endfunction

  // Work out the tokens one accepted input word causes and queue them.
  function automatic void tokenize_word(tok_in_t w);
    tok_out_t t;
    step_tokens.delete();
    if (w.func == FUNC_END) begin
      if (!block_failed) begin
        if (quote_held) quoted = 1'b0;
        if (quoted) begin
          emit(KIND_ERROR, 8'h00, ERR_QUOTE);
        end else if (cell_open || row_cells != 0) begin
          // flush the last row, then flag it if it breaks a limit
          emit(KIND_ROW_END, 8'h00, ERR_COLUMNS);
          if (row_cells + 1 > lim_columns || block_rows + 1 > lim_rows)
            emit(KIND_ERROR, 8'h00, ERR_END_LIMITS);
        end
      end
      quoted       = 1'b0;
      quote_held   = 1'b0;
      cell_open    = 1'b0;
      block_failed = 1'b0;
      row_cells    = '0;
      block_rows   = '0;
    end else if (!block_failed) begin
      take_byte(w.byte_in);
    end
    if (step_tokens.size() != 0) begin
      t = step_tokens.pop_back();
      t.last_of_run = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void check_token(tok_out_t got);
    tok_out_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected word: kind %0d byte %02h code %0d last %0b",
             got.kind, got.cell_byte, got.error_code, got.last_of_run);
      fail_count++;
    end else begin
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.cell_byte !== want.cell_byte) begin
        $error("cell_byte: expected %02h, got %02h", want.cell_byte, got.cell_byte);
        fail_count++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        fail_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        fail_count++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: predict on acceptance, then load the next word when the slot
  // is free. A stalled word is held untouched.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tokenize_word(in_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted token, stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_token(out_word);
      out_stall <= !steady && ($urandom_range(99) < 28);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus builders: append words to the pending queue.
  // ---------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] c);
    tok_in_t w;
    w.func    = FUNC_DATA;
    w.byte_in = c;
    pending_words.push_back(w);
  endfunction

  function automatic void put_text(string s);
    foreach (s[i]) put_byte(s[i]);
  endfunction

  function automatic void put_end();
    tok_in_t w;
    w.func    = FUNC_END;
    w.byte_in = 8'($urandom_range(255));  // ignored by the block
    pending_words.push_back(w);
  endfunction

  // Mostly letters; now and then any byte at all, specials included.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    if ($urandom_range(7) == 0) begin
      c = 8'($urandom_range(255));
    end else begin
      c = 8'(8'h61 + $urandom_range(25));
    end
    return c;
  endfunction

  // Rows or cells per row: up to one past the limit, capped to keep blocks short.
  function automatic int unsigned span(int unsigned lim);
    return (lim >= 4) ? 5 : lim + 1;
  endfunction

  function automatic void put_cell();
    int unsigned len;
    len = $urandom_range(4);
    case ($urandom_range(2))
      0: ;  // empty cell
      1: begin
        repeat (len) put_byte(plain_byte());
        if ($urandom_range(5) == 0) put_byte(ChCr);
      end
      default: begin
        put_byte(ChQuote);
        repeat (len) begin
          case ($urandom_range(5))
            0: put_byte(ChComma);
            1: put_byte(ChLf);
            2: put_byte(ChCr);
            3: begin
              put_byte(ChQuote);
              put_byte(ChQuote);
            end
            default: put_byte(plain_byte());
          endcase
        end
        // now and then leave the quote open: a broken cell
        if ($urandom_range(29) != 0) put_byte(ChQuote);
      end
    endcase
  endfunction

  // One block of rows and cells with random content, sized around the limits.
  function automatic void put_block();
    int unsigned n_rows;
    int unsigned n_cols;
    n_rows = $urandom_range(span(lim_rows), 1);
    for (int r = 0; r < n_rows; r++) begin
      n_cols = $urandom_range(span(lim_columns), 1);
      for (int c = 0; c < n_cols; c++) begin
        put_cell();
        if (c < n_cols - 1) put_byte(ChComma);
      end
      // last row may end without a newline; the end mark flushes it
      if (r < n_rows - 1 || $urandom_range(1) == 1) begin
        if ($urandom_range(3) == 0) put_byte(ChCr);
        put_byte(ChLf);
      end
    end
    put_end();
  endfunction

  // Noise: a short run of bytes heavy in specials, then the end mark.
  function automatic void put_noise();
    repeat ($urandom_range(10, 1)) begin
      case ($urandom_range(5))
        0: put_byte(ChQuote);
        1: put_byte(ChComma);
        2: put_byte(ChLf);
        3: put_byte(ChCr);
        default: put_byte(8'($urandom_range(255)));
      endcase
    end
    put_end();
  endfunction

  function automatic void fill(int unsigned budget);
    int unsigned goal;
    goal = pending_words.size() + budget;
    while (pending_words.size() < goal) begin
      if ($urandom_range(4) == 0) begin
        put_noise();
      end else begin
        put_block();
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Phase control. Sample at the falling edge so that the driver's and
  // monitor's updates of the rising edge are all settled.
  // ---------------------------------------------------------------------
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_tokens.size() != 0);
    // a last word with no token may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limits(int unsigned cols, int unsigned rows);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_COLUMNS;
    cfg_data  <= CfgDataW'(cols);
    @(posedge clk);
    cfg_index <= CFG_MAX_ROWS;
    cfg_data  <= CfgDataW'(rows);
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_columns = MaxColumnsW'(cols);
    lim_rows    = MaxRowsW'(rows);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Default limits. Quoted cell with a doubled quote, quotes closed by a
    // comma, carriage return dropped, byte extremes, then a held quote at
    // the end mark flushing the last row.
    put_text("\"a\"\"b\",");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(ChCr);
    put_byte(ChLf);
    put_text("\"c\"");
    put_end();
    // unfinished quote at the end mark, then an empty block
    put_byte(ChQuote);
    put_end();
    put_end();
    drain();

    // One row allowed: second newline overflows the rows.
    set_limits(1, 1);
    put_byte(ChLf);
    put_byte(ChLf);
    put_end();
    drain();

    // Zero limits: every cell end overflows, later bytes are dropped, and
    // a last row flushed at the end mark is flagged.
    set_limits(0, 0);
    put_text("x,y");
    put_end();
    put_text("x");
    put_end();
    drain();

    // Random blocks over a range of limits, extremes included.
    set_limits(1023, 65535);
    fill(150);
    drain();

    steady = 1'b1;  // long stretch with no idling on either side
    set_limits(3, 4);
    fill(200);
    drain();
    steady = 1'b0;

    set_limits(1, 1);
    fill(100);
    drain();

    set_limits($urandom_range(8, 1), $urandom_range(8, 1));
    fill(150);
    drain();

    set_limits($urandom_range(1023, 1), $urandom_range(65535, 1));
    fill(100);
    drain();

    set_limits(1023, 2);
    fill(100);
    drain();

    set_limits(MaxColumnsReset, MaxRowsReset);
    fill(100);
    drain();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
